// ===== rtl/rmfh_pkg.sv =====
package rmfh_pkg;

  // Request operation codes. Bit 1 set means initialize, whatever bit 0 holds.
  localparam logic [1:0] OP_ACQUIRE  = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam int unsigned OP_INIT_BIT = 1;

  typedef enum logic [3:0] {
    STATUS_GRANTED   = 4'd0,
    STATUS_RECURSIVE = 4'd1,
    STATUS_QUEUED    = 4'd2,
    STATUS_HELD      = 4'd3,
    STATUS_FREED     = 4'd4,
    STATUS_HANDOFF   = 4'd5,
    STATUS_INIT      = 4'd6,
    STATUS_NOT_OWNER = 4'd7,
    STATUS_QFULL     = 4'd8,
    STATUS_OVERFLOW  = 4'd9
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_stat_t;

endpackage

// ===== rtl/rmfh_req_if.sv =====
interface rmfh_req_if #(
  parameter int unsigned TID_W = 8
);
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [TID_W-1:0] thread_id;
  logic             init_owned;

  modport source (output valid, output operation, output thread_id, output init_owned,
                  input ready);
  modport sink   (input valid, input operation, input thread_id, input init_owned,
                  output ready);
endinterface

// ===== rtl/rmfh_rsp_if.sv =====
interface rmfh_rsp_if #(
  parameter int unsigned TID_W = 8,
  parameter int unsigned CNT_W = 16
);
  logic               valid;
  logic               ready;
  rmfh_pkg::status_e  status;
  logic               woken_valid;
  logic [TID_W-1:0]   woken_thread;
  logic               owner_valid;
  logic [TID_W-1:0]   owner_thread;
  logic [CNT_W-1:0]   hold_count;

  modport source (output valid, output status, output woken_valid, output woken_thread,
                  output owner_valid, output owner_thread, output hold_count,
                  input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_thread,
                  input owner_valid, input owner_thread, input hold_count,
                  output ready);
endinterface

// ===== rtl/recursive_mutex_fifo_handoff.sv =====
// Recursive lock with a FIFO of waiting threads. Each request beat (acquire, release
// or initialize) produces exactly one result beat carrying a status code, the thread
// woken by a handoff and the owner and hold count after the request. A request is first
// captured while the head of the wait queue is read from the queue memory; then owner,
// count and queue pointers are updated and the result register is loaded, which waits
// while that register still holds a result not yet taken. The result register
// decouples the two sides, so the next request is taken while a finished result
// still waits, but only after the previous request has executed. No clearing pass
// is needed after reset: a queue entry's value is used only after it was written.
module recursive_mutex_fifo_handoff #(
  parameter int unsigned THREAD_ID_BITS = 8,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned COUNT_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmfh_req_if.sink   req_i,
  rmfh_rsp_if.source rsp_o
);
  import rmfh_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rmfh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmfh_datapath #(
    .TID_W       (THREAD_ID_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (req_i.operation),
    .thread_id_i  (req_i.thread_id),
    .init_owned_i (req_i.init_owned),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== rtl/rmfh_ctrl.sv =====
module rmfh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  rmfh_pkg::dp_stat_t  stat_i,
  output rmfh_pkg::ctrl_cmd_t cmd_o
);
  import rmfh_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !stat_i.out_stall;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !req_ready_o) else $error("request taken while busy");
  a_load_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EXEC) else $error("load did not start execution");
  a_no_exec_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.out_stall |-> !cmd_o.exec) else $error("executed into a full result register");

endmodule

// ===== rtl/rmfh_datapath.sv =====
module rmfh_datapath #(
  parameter int unsigned TID_W       = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CNT_W       = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmfh_pkg::ctrl_cmd_t cmd_i,
  output rmfh_pkg::dp_stat_t  stat_o,
  input  logic [1:0]          operation_i,
  input  logic [TID_W-1:0]    thread_id_i,
  input  logic                init_owned_i,
  rmfh_rsp_if.source          rsp_o
);
  import rmfh_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LastSlot = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FullFill = FILL_W'(QUEUE_DEPTH);

  // Captured request and the queue head read at capture time.
  logic [1:0]       op_q;
  logic [TID_W-1:0] tid_q;
  logic             init_own_q;
  logic [TID_W-1:0] head_data_q;

  logic [TID_W-1:0] wait_mem_q [QUEUE_DEPTH];

  logic             owned_q, owned_d;
  logic [TID_W-1:0] owner_q, owner_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic             rsp_valid_q;
  status_e          status_q, status_d;
  logic             woken_v_q, woken_v_d;
  logic [TID_W-1:0] woken_t_q, woken_t_d;
  logic             enq;

  assign stat_o.out_stall = rsp_valid_q && !rsp_o.ready;

  always_comb begin
    owned_d   = owned_q;
    owner_d   = owner_q;
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    woken_v_d = 1'b0;
    woken_t_d = '0;
    enq       = 1'b0;
    status_d  = STATUS_INIT;
    if (op_q[OP_INIT_BIT]) begin
      head_d   = '0;
      tail_d   = '0;
      fill_d   = '0;
      owned_d  = init_own_q;
      owner_d  = init_own_q ? tid_q : '0;
      count_d  = init_own_q ? CNT_W'(1) : '0;
      status_d = STATUS_INIT;
    end else if (op_q == OP_ACQUIRE) begin
      if (owned_q && owner_q == tid_q) begin
        if (&count_q) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          count_d  = count_q + CNT_W'(1);
          status_d = STATUS_RECURSIVE;
        end
      end else if (!owned_q) begin
        owned_d  = 1'b1;
        owner_d  = tid_q;
        count_d  = CNT_W'(1);
        status_d = STATUS_GRANTED;
      end else if (fill_q == FullFill) begin
        status_d = STATUS_QFULL;
      end else begin
        enq      = 1'b1;
        tail_d   = (tail_q == LastSlot) ? '0 : tail_q + PTR_W'(1);
        fill_d   = fill_q + FILL_W'(1);
        status_d = STATUS_QUEUED;
      end
    end else begin
      if (!owned_q || owner_q != tid_q) begin
        status_d = STATUS_NOT_OWNER;
      end else if (count_q > CNT_W'(1)) begin
        count_d  = count_q - CNT_W'(1);
        status_d = STATUS_HELD;
      end else if (fill_q == '0) begin
        owned_d  = 1'b0;
        owner_d  = '0;
        count_d  = '0;
        status_d = STATUS_FREED;
      end else begin
        woken_v_d = 1'b1;
        woken_t_d = head_data_q;
        head_d    = (head_q == LastSlot) ? '0 : head_q + PTR_W'(1);
        fill_d    = fill_q - FILL_W'(1);
        owner_d   = head_data_q;
        count_d   = CNT_W'(1);
        status_d  = STATUS_HANDOFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned_q     <= 1'b0;
      owner_q     <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        owned_q <= owned_d;
        owner_q <= owner_d;
        count_q <= count_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        fill_q  <= fill_d;
      end
      if (cmd_i.exec) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, queue memory and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= operation_i;
      tid_q       <= thread_id_i;
      init_own_q  <= init_owned_i;
      head_data_q <= wait_mem_q[head_q];
    end
    if (cmd_i.exec && enq) begin
      wait_mem_q[tail_q] <= tid_q;
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      woken_v_q <= woken_v_d;
      woken_t_q <= woken_t_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.woken_valid  = woken_v_q;
  assign rsp_o.woken_thread = woken_t_q;
  assign rsp_o.owner_valid  = owned_q;
  assign rsp_o.owner_thread = owned_q ? owner_q : '0;
  assign rsp_o.hold_count   = owned_q ? count_q : '0;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill) else $error("wait queue fill beyond depth");
  a_free_has_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !owned_q |-> count_q == '0) else $error("free lock with nonzero count");
  a_owned_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owned_q |-> count_q != '0) else $error("owned lock with zero count");
  a_exec_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> rsp_valid_q) else $error("result beat missing after execution");

endmodule
